// ===== hdl/dispersion_coefficients_macros.svh =====
// Assertion macros shared by the dispersion coefficient block.
`ifndef DISPERSION_COEFFICIENTS_MACROS_SVH
`define DISPERSION_COEFFICIENTS_MACROS_SVH
`ifndef SYNTHESIS
`define DC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispersion_coefficients: same-cycle check failed");
`define DC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispersion_coefficients: next-cycle check failed");
`else
`define DC_ASSERT_IMP(lbl, ante, cons)
`define DC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/dc_pkg.sv =====
`default_nettype none

package dc_pkg;

    localparam int VEL_W      = 32;
    localparam int SQ_W       = 64;
    localparam int SSUM_W     = 65;
    localparam int AX_W       = 33;
    localparam int ROOT_W     = 34;
    localparam int SQRT_STEPS = 34;
    localparam int SQRT_IN_W  = 68;
    localparam int SQRT_REM_W = 36;
    localparam int AXSQ_W     = 65;
    localparam int OTH_W      = 66;
    localparam int SPLIT_W    = 33;
    localparam int PL_LO_W    = 65;
    localparam int PL_HI_W    = 64;
    localparam int PT_LO_W    = 65;
    localparam int PT_HI_W    = 65;
    localparam int NL_W       = 97;
    localparam int NUM_W      = 98;
    localparam int DIV_STEPS  = 32;
    localparam int QUO_W      = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int LANES      = 3;
    localparam int FACES      = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG   = 2'd0,
        REG_TRANS  = 2'd1,
        REG_MOLDIF = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic adv;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/dispersion_coefficients.sv =====
// Diagonal dispersion coefficients of one grid cell, fixed point with FRAC_BITS
// fractional bits.
// Input channel: in_valid/in_ready carry the six face velocities of one cell.
// Output channel: out_valid/out_ready carry disp_x, disp_y, disp_z and the
// saturated flag, one result per request, in request order.
// Configuration: cfg_we writes cfg_data into the register cfg_index selects
// (0 longitudinal, 1 transverse, 2 molecular diffusion); other indexes are
// ignored. Write only while no request is in flight.
// The pipeline runs the squares and sums, the two-bit-per-stage square root,
// the products and the overflow check, the one-bit-per-stage divider and the
// output register. Every stage is a register.
// Throughput is one request per cycle unless the receiver stalls.
// Reset clears the configuration registers and all stage valid bits.
// A stalled receiver freezes the whole pipeline: in_ready drops in the same
// cycle, and no request is lost or repeated.
`default_nettype none
`include "dispersion_coefficients_macros.svh"

module dispersion_coefficients #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [dc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [dc_pkg::CFG_W-1:0]               cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [dc_pkg::VEL_W-1:0]        vel_face0,
    input  logic signed [dc_pkg::VEL_W-1:0]        vel_face1,
    input  logic signed [dc_pkg::VEL_W-1:0]        vel_face2,
    input  logic signed [dc_pkg::VEL_W-1:0]        vel_face3,
    input  logic signed [dc_pkg::VEL_W-1:0]        vel_face4,
    input  logic signed [dc_pkg::VEL_W-1:0]        vel_face5,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [dc_pkg::QUO_W-1:0]               disp_x,
    output logic [dc_pkg::QUO_W-1:0]               disp_y,
    output logic [dc_pkg::QUO_W-1:0]               disp_z,
    output logic                                   saturated
);

    localparam int SHIFT   = 2 + FRAC_BITS;
    localparam int NS_W    = dc_pkg::NUM_W - SHIFT;
    localparam int HI_W    = NS_W - dc_pkg::QUO_W;
    localparam int L       = dc_pkg::LANES;
    localparam int F       = dc_pkg::FACES;
    localparam int AX_W    = dc_pkg::AX_W;
    localparam int RW      = dc_pkg::ROOT_W;
    localparam int QW      = dc_pkg::QUO_W;
    localparam int SP      = dc_pkg::SPLIT_W;
    localparam int SIDE1_W = 1 + L * AX_W;
    localparam int SIDE2_W = 1 + L;

    logic [dc_pkg::CFG_W-1:0] long_reg;
    logic [dc_pkg::CFG_W-1:0] trans_reg;
    logic [dc_pkg::CFG_W-1:0] moldif_reg;

    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg   <= '0;
            trans_reg  <= '0;
            moldif_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dc_pkg::REG_LONG:   long_reg   <= cfg_data;
                dc_pkg::REG_TRANS:  trans_reg  <= cfg_data;
                dc_pkg::REG_MOLDIF: moldif_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // squares and axis sums
    logic signed [dc_pkg::VEL_W-1:0] vel [F];
    logic [dc_pkg::SQ_W-1:0]         a1_sq_next [F];
    logic [AX_W-1:0]                 a1_ax_next [L];
    logic                            a1_valid_reg;
    logic [dc_pkg::SQ_W-1:0]         a1_sq_reg [F];
    logic [AX_W-1:0]                 a1_ax_reg [L];

    assign vel[0] = vel_face0;
    assign vel[1] = vel_face1;
    assign vel[2] = vel_face2;
    assign vel[3] = vel_face3;
    assign vel[4] = vel_face4;
    assign vel[5] = vel_face5;

    always_comb
    begin
        logic [dc_pkg::VEL_W-1:0]        mag [F];
        logic signed [dc_pkg::SQ_W-1:0]  prod;
        for (int i = 0; i < F; i++)
        begin
            mag[i]        = vel[i][dc_pkg::VEL_W-1] ? (~vel[i] + 1'b1) : vel[i];
            prod          = vel[i] * vel[i];
            a1_sq_next[i] = prod;
        end
        a1_ax_next[0] = {1'b0, mag[2]} + {1'b0, mag[4]};
        a1_ax_next[1] = {1'b0, mag[1]} + {1'b0, mag[3]};
        a1_ax_next[2] = {1'b0, mag[0]} + {1'b0, mag[5]};
    end

    logic                            a2_valid_reg;
    logic [dc_pkg::SSUM_W-1:0]       a2_pair_reg [L];
    logic [AX_W-1:0]                 a2_ax_reg   [L];
    logic                            a3_valid_reg;
    logic [dc_pkg::SSUM_W-1:0]       a3_sum_reg;
    logic                            a3_zero_reg;
    logic [AX_W-1:0]                 a3_ax_reg   [L];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
            a3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a1_valid_reg <= in_valid;
            a2_valid_reg <= a1_valid_reg;
            a3_valid_reg <= a2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_sq_reg <= a1_sq_next;
            a1_ax_reg <= a1_ax_next;
            for (int j = 0; j < L; j++)
            begin
                a2_pair_reg[j] <= {1'b0, a1_sq_reg[2*j]} + {1'b0, a1_sq_reg[2*j+1]};
            end
            a2_ax_reg  <= a1_ax_reg;
            a3_sum_reg <= a2_pair_reg[0] + a2_pair_reg[1] + a2_pair_reg[2];
            a3_zero_reg <= (a2_pair_reg[0] == '0) && (a2_pair_reg[1] == '0)
                           && (a2_pair_reg[2] == '0);
            a3_ax_reg  <= a2_ax_reg;
        end
    end

    // speed
    dc_pkg::pipe_ctl_t  sq_ctl;
    logic               sq_valid;
    logic [RW-1:0]      sq_root;
    logic [SIDE1_W-1:0] sq_side;

    assign sq_ctl.adv   = adv;
    assign sq_ctl.valid = a3_valid_reg;

    dc_isqrt #(
        .SIDE_W (SIDE1_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sq_ctl),
        .radicand  (a3_sum_reg),
        .side_in   ({a3_zero_reg, a3_ax_reg[0], a3_ax_reg[1], a3_ax_reg[2]}),
        .valid_out (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // numerators
    logic                        b1_valid_reg;
    logic [dc_pkg::AXSQ_W-1:0]   b1_axsq_reg [L];
    logic [RW-1:0]               b1_speed_reg;
    logic                        b1_zero_reg;
    logic                        b2_valid_reg;
    logic [dc_pkg::AXSQ_W-1:0]   b2_own_reg [L];
    logic [dc_pkg::OTH_W-1:0]    b2_oth_reg [L];
    logic [RW-1:0]               b2_speed_reg;
    logic                        b2_zero_reg;
    logic                        b3_valid_reg;
    logic [dc_pkg::PL_LO_W-1:0]  b3_pl_lo_reg [L];
    logic [dc_pkg::PL_HI_W-1:0]  b3_pl_hi_reg [L];
    logic [dc_pkg::PT_LO_W-1:0]  b3_pt_lo_reg [L];
    logic [dc_pkg::PT_HI_W-1:0]  b3_pt_hi_reg [L];
    logic [RW-1:0]               b3_speed_reg;
    logic                        b3_zero_reg;
    logic                        b4_valid_reg;
    logic [dc_pkg::NL_W-1:0]     b4_nl_reg [L];
    logic [dc_pkg::NUM_W-1:0]    b4_nt_reg [L];
    logic [RW-1:0]               b4_speed_reg;
    logic                        b4_zero_reg;
    logic                        b5_valid_reg;
    logic [NS_W-1:0]             b5_ns_reg [L];
    logic [RW-1:0]               b5_speed_reg;
    logic                        b5_zero_reg;
    logic                        b6_valid_reg;
    logic [L-1:0][RW-1:0]        b6_rem_reg;
    logic [L-1:0][QW-1:0]        b6_lo_reg;
    logic [L-1:0]                b6_ovf_reg;
    logic [RW-1:0]               b6_speed_reg;
    logic                        b6_zero_reg;

    logic [AX_W-1:0]             sq_ax [L];
    logic [dc_pkg::NUM_W-1:0]    b5_num_next [L];

    assign sq_ax[0] = sq_side[3*AX_W-1:2*AX_W];
    assign sq_ax[1] = sq_side[2*AX_W-1:AX_W];
    assign sq_ax[2] = sq_side[AX_W-1:0];

    always_comb
    begin
        for (int j = 0; j < L; j++)
        begin
            b5_num_next[j] = dc_pkg::NUM_W'(b4_nl_reg[j]) + b4_nt_reg[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
            b6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg <= sq_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
            b6_valid_reg <= b5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < L; j++)
            begin
                b1_axsq_reg[j] <= dc_pkg::AXSQ_W'(sq_ax[j] * sq_ax[j]);
            end
            b1_speed_reg <= sq_root;
            b1_zero_reg  <= sq_side[SIDE1_W-1];

            b2_own_reg    <= b1_axsq_reg;
            b2_oth_reg[0] <= {1'b0, b1_axsq_reg[1]} + {1'b0, b1_axsq_reg[2]};
            b2_oth_reg[1] <= {1'b0, b1_axsq_reg[0]} + {1'b0, b1_axsq_reg[2]};
            b2_oth_reg[2] <= {1'b0, b1_axsq_reg[0]} + {1'b0, b1_axsq_reg[1]};
            b2_speed_reg  <= b1_speed_reg;
            b2_zero_reg   <= b1_zero_reg;

            for (int j = 0; j < L; j++)
            begin
                b3_pl_lo_reg[j] <= long_reg * b2_own_reg[j][SP-1:0];
                b3_pl_hi_reg[j] <= long_reg * b2_own_reg[j][dc_pkg::AXSQ_W-1:SP];
                b3_pt_lo_reg[j] <= trans_reg * b2_oth_reg[j][SP-1:0];
                b3_pt_hi_reg[j] <= trans_reg * b2_oth_reg[j][dc_pkg::OTH_W-1:SP];
            end
            b3_speed_reg <= b2_speed_reg;
            b3_zero_reg  <= b2_zero_reg;

            for (int j = 0; j < L; j++)
            begin
                b4_nl_reg[j] <= {b3_pl_hi_reg[j], {SP{1'b0}}}
                                + dc_pkg::NL_W'(b3_pl_lo_reg[j]);
                b4_nt_reg[j] <= {b3_pt_hi_reg[j], {SP{1'b0}}}
                                + dc_pkg::NUM_W'(b3_pt_lo_reg[j]);
            end
            b4_speed_reg <= b3_speed_reg;
            b4_zero_reg  <= b3_zero_reg;

            for (int j = 0; j < L; j++)
            begin
                b5_ns_reg[j] <= b5_num_next[j][dc_pkg::NUM_W-1:SHIFT];
            end
            b5_speed_reg <= b4_speed_reg;
            b5_zero_reg  <= b4_zero_reg;

            for (int j = 0; j < L; j++)
            begin
                b6_ovf_reg[j] <= (b5_ns_reg[j][NS_W-1:QW] >= HI_W'(b5_speed_reg));
                b6_rem_reg[j] <= b5_ns_reg[j][QW+RW-1:QW];
                b6_lo_reg[j]  <= b5_ns_reg[j][QW-1:0];
            end
            b6_speed_reg <= b5_speed_reg;
            b6_zero_reg  <= b5_zero_reg;
        end
    end

    // quotients
    dc_pkg::pipe_ctl_t     dv_ctl;
    logic                  dv_valid;
    logic [L-1:0][QW-1:0]  dv_quo;
    logic [SIDE2_W-1:0]    dv_side;
    logic                  dv_zero;
    logic [L-1:0]          dv_ovf;

    assign dv_ctl.adv   = adv;
    assign dv_ctl.valid = b6_valid_reg;
    assign dv_zero      = dv_side[SIDE2_W-1];
    assign dv_ovf       = dv_side[L-1:0];

    dc_div #(
        .SIDE_W (SIDE2_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (dv_ctl),
        .rem_in    (b6_rem_reg),
        .num_lo    (b6_lo_reg),
        .divisor   (b6_speed_reg),
        .side_in   ({b6_zero_reg, b6_ovf_reg}),
        .valid_out (dv_valid),
        .quotient  (dv_quo),
        .side_out  (dv_side)
    );

    // add diffusion, clip
    logic [QW-1:0] disp_next [L];
    logic          sat_next;
    logic [QW-1:0] disp_reg  [L];
    logic          sat_reg;

    always_comb
    begin
        logic [QW:0]  qsum;
        logic [L-1:0] lane_sat;
        for (int j = 0; j < L; j++)
        begin
            qsum        = {1'b0, dv_quo[j]} + {1'b0, moldif_reg};
            lane_sat[j] = dv_ovf[j] || qsum[QW];
            if (dv_zero)
            begin
                disp_next[j] = moldif_reg;
            end
            else if (lane_sat[j])
            begin
                disp_next[j] = '1;
            end
            else
            begin
                disp_next[j] = qsum[QW-1:0];
            end
        end
        sat_next = !dv_zero && (lane_sat != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            disp_reg <= disp_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign disp_x    = disp_reg[0];
    assign disp_y    = disp_reg[1];
    assign disp_z    = disp_reg[2];
    assign saturated = sat_reg;

    `DC_ASSERT_IMP(a_sat_clips, out_valid && saturated, disp_x == '1 || disp_y == '1 || disp_z == '1)
    `DC_ASSERT_NXT(a_stall_holds, !in_ready, $stable(a1_valid_reg) && $stable(b6_valid_reg))
    `DC_ASSERT_NXT(a_zero_unsat, adv && dv_valid && dv_zero, !saturated)

endmodule

`default_nettype wire

// ===== hdl/dc_isqrt.sv =====
`default_nettype none

module dc_isqrt #(
    parameter int SIDE_W = 100
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dc_pkg::pipe_ctl_t            ctl,
    input  logic [dc_pkg::SSUM_W-1:0]    radicand,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         valid_out,
    output logic [dc_pkg::ROOT_W-1:0]    root,
    output logic [SIDE_W-1:0]            side_out
);

    localparam int N     = dc_pkg::SQRT_STEPS;
    localparam int REM_W = dc_pkg::SQRT_REM_W;
    localparam int RT_W  = dc_pkg::ROOT_W;
    localparam int IN_W  = dc_pkg::SQRT_IN_W;

    logic              valid_reg [N];
    logic [REM_W-1:0]  rem_reg   [N];
    logic [RT_W-1:0]   root_reg  [N];
    logic [IN_W-1:0]   rad_reg   [N];
    logic [SIDE_W-1:0] side_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic              v_in;
        logic [REM_W-1:0]  rem_in;
        logic [RT_W-1:0]   root_in;
        logic [IN_W-1:0]   rad_in;
        logic [SIDE_W-1:0] sd_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [RT_W-1:0]   root_next;
        logic [IN_W-1:0]   rad_next;

        if (k == 0) begin : g_first
            assign v_in    = ctl.valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = IN_W'(radicand);
            assign sd_in   = side_in;
        end
        else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign sd_in   = side_reg[k-1];
        end

        assign cur       = {rem_in, rad_in[IN_W-1 -: 2]};
        assign trial     = {{(REM_W-RT_W){1'b0}}, root_in, 2'b01};
        assign take      = (cur >= trial);
        assign rem_next  = take ? REM_W'(cur - trial) : REM_W'(cur);
        assign root_next = {root_in[RT_W-2:0], take};
        assign rad_next  = {rad_in[IN_W-3:0], 2'b00};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ctl.adv)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
                side_reg[k] <= sd_in;
            end
        end
    end

    assign valid_out = valid_reg[N-1];
    assign root      = root_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

`default_nettype wire

// ===== hdl/dc_div.sv =====
`default_nettype none

module dc_div #(
    parameter int SIDE_W = 4
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  dc_pkg::pipe_ctl_t                                ctl,
    input  logic [dc_pkg::LANES-1:0][dc_pkg::ROOT_W-1:0]     rem_in,
    input  logic [dc_pkg::LANES-1:0][dc_pkg::QUO_W-1:0]      num_lo,
    input  logic [dc_pkg::ROOT_W-1:0]                        divisor,
    input  logic [SIDE_W-1:0]                                side_in,
    output logic                                             valid_out,
    output logic [dc_pkg::LANES-1:0][dc_pkg::QUO_W-1:0]      quotient,
    output logic [SIDE_W-1:0]                                side_out
);

    localparam int N  = dc_pkg::DIV_STEPS;
    localparam int L  = dc_pkg::LANES;
    localparam int RW = dc_pkg::ROOT_W;
    localparam int QW = dc_pkg::QUO_W;

    logic                       valid_reg [N];
    logic [L-1:0][RW-1:0]       rem_reg   [N];
    logic [L-1:0][QW-1:0]       lo_reg    [N];
    logic [RW-1:0]              div_reg   [N];
    logic [SIDE_W-1:0]          side_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic                 v_in;
        logic [L-1:0][RW-1:0] r_in;
        logic [L-1:0][QW-1:0] l_in;
        logic [RW-1:0]        d_in;
        logic [SIDE_W-1:0]    sd_in;
        logic [L-1:0][RW-1:0] rem_next;
        logic [L-1:0][QW-1:0] lo_next;

        if (k == 0) begin : g_first
            assign v_in  = ctl.valid;
            assign r_in  = rem_in;
            assign l_in  = num_lo;
            assign d_in  = divisor;
            assign sd_in = side_in;
        end
        else begin : g_rest
            assign v_in  = valid_reg[k-1];
            assign r_in  = rem_reg[k-1];
            assign l_in  = lo_reg[k-1];
            assign d_in  = div_reg[k-1];
            assign sd_in = side_reg[k-1];
        end

        always_comb
        begin
            logic [RW:0] t;
            logic        ge;
            for (int j = 0; j < L; j++)
            begin
                t           = {r_in[j], l_in[j][QW-1]};
                ge          = (t >= {1'b0, d_in});
                rem_next[j] = ge ? RW'(t - {1'b0, d_in}) : RW'(t);
                lo_next[j]  = {l_in[j][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ctl.adv)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                rem_reg[k]  <= rem_next;
                lo_reg[k]   <= lo_next;
                div_reg[k]  <= d_in;
                side_reg[k] <= sd_in;
            end
        end
    end

    assign valid_out = valid_reg[N-1];
    assign quotient  = lo_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

`default_nettype wire

// ===== bench/dispersion_coefficients_tb.sv =====
`timescale 1ns / 100ps

module dispersion_coefficients_tb;

    localparam int FRAC = 24;
    localparam int LIMIT = 400000;
    localparam int DRAIN_WAIT = 100;
    localparam logic [dc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [dc_pkg::VEL_W-1:0] vel_t;
    typedef struct {
        logic [dc_pkg::QUO_W-1:0] dx;
        logic [dc_pkg::QUO_W-1:0] dy;
        logic [dc_pkg::QUO_W-1:0] dz;
        logic sat;
    } coef_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [dc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dc_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    vel_t face [6];
    logic out_valid;
    logic out_ready = 1'b0;
    logic [dc_pkg::QUO_W-1:0] disp_x, disp_y, disp_z;
    logic saturated;

    logic [31:0] long_disp = '0;
    logic [31:0] trans_disp = '0;
    logic [31:0] mol_diff = '0;
    coef_t expected_coefs [$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int hold_request = 0;
    int hold_left = 0;

    initial begin
        for (int i = 0; i < 6; i++)
        begin
            face[i] = '0;
        end
    end

    dispersion_coefficients u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .vel_face0(face[0]), .vel_face1(face[1]), .vel_face2(face[2]),
        .vel_face3(face[3]), .vel_face4(face[4]), .vel_face5(face[5]),
        .out_valid(out_valid), .out_ready(out_ready),
        .disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z), .saturated(saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit [127:0] face_mag(vel_t v);
        bit [32:0] m;
        m = v[31] ? ({1'b0, ~v} + 33'd1) : {1'b0, v};
        return {95'd0, m};
    endfunction

    function automatic bit [127:0] cell_speed(bit [127:0] s);
        bit [127:0] r;
        bit [127:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] axis_coef(bit [127:0] own, bit [127:0] o1,
                                              bit [127:0] o2, bit [127:0] speed,
                                              ref logic sat);
        bit [127:0] n;
        bit [127:0] q;
        n = own * own * long_disp + (o1 * o1 + o2 * o2) * trans_disp;
        q = (n / (speed << 2)) >> FRAC;
        if (q > {96'd0, 32'hFFFF_FFFF - mol_diff})
        begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return q[31:0] + mol_diff;
    endfunction

    function automatic coef_t predict_coefs(vel_t v [6]);
        coef_t r;
        bit [127:0] m [6];
        bit [127:0] s;
        bit [127:0] speed;
        logic sat;
        s = '0;
        sat = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            m[i] = face_mag(v[i]);
            s += m[i] * m[i];
        end
        if (s == 0)
        begin
            r.dx = mol_diff;
            r.dy = mol_diff;
            r.dz = mol_diff;
            r.sat = 1'b0;
            return r;
        end
        speed = cell_speed(s);
        r.dx = axis_coef(m[2] + m[4], m[1] + m[3], m[0] + m[5], speed, sat);
        r.dy = axis_coef(m[1] + m[3], m[2] + m[4], m[0] + m[5], speed, sat);
        r.dz = axis_coef(m[0] + m[5], m[2] + m[4], m[1] + m[3], speed, sat);
        r.sat = sat;
        return r;
    endfunction

    // Predict on accepted requests, check accepted results.
    always @(posedge clk)
    begin
        coef_t e;
        if (rst_n && in_valid && in_ready)
            expected_coefs.push_back(predict_coefs(face));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_coefs.size() == 0)
            begin
                $error("unexpected result x=%h y=%h z=%h", disp_x, disp_y, disp_z);
                errors++;
            end
            else
            begin
                e = expected_coefs.pop_front();
                if (disp_x !== e.dx)
                begin
                    $error("disp_x expected %h actual %h", e.dx, disp_x);
                    errors++;
                end
                if (disp_y !== e.dy)
                begin
                    $error("disp_y expected %h actual %h", e.dy, disp_y);
                    errors++;
                end
                if (disp_z !== e.dz)
                begin
                    $error("disp_z expected %h actual %h", e.dz, disp_z);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated expected %b actual %b", e.sat, saturated);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls plus a requested long hold-off.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(99) < 8)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_cell(vel_t v [6]);
        if (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            face[i] <= v[i];
        end
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        while (expected_coefs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [dc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == dc_pkg::REG_LONG)
            long_disp = val;
        else if (idx == dc_pkg::REG_TRANS)
            trans_disp = val;
        else if (idx == dc_pkg::REG_MOLDIF)
            mol_diff = val;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] l, logic [31:0] t, logic [31:0] d);
        go_idle();
        write_reg(dc_pkg::REG_LONG, l);
        write_reg(dc_pkg::REG_TRANS, t);
        write_reg(dc_pkg::REG_MOLDIF, d);
        @(posedge clk);
    endtask

    function automatic vel_t rand_vel();
        case ($urandom_range(5))
            0: return '0;
            1: return $urandom_range(1, 32'h0400_0000);
            2: return -$signed({1'b0, 31'($urandom_range(1, 32'h0400_0000))});
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_cfg();
        case ($urandom_range(4))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h0400_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int count);
        vel_t v [6];
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                v[i] = rand_vel();
            end
            send_cell(v);
        end
    endtask

    task automatic test_directed();
        vel_t v [6];
        logic [31:0] pats [8] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000,
                                  32'hFF00_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0080_0000};
        set_config(32'h0100_0000, 32'h0010_0000, 32'h0001_0000);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        for (int p = 0; p < 8; p++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                v[i] = pats[p];
            end
            send_cell(v);
        end
        // one face at a time covers the axis pairing
        for (int f = 0; f < 6; f++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                v[i] = (i == f) ? 32'h0200_0000 : 32'h0;
            end
            send_cell(v);
        end
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int p = 0; p < 4; p++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                v[i] = pats[p + i % 2];
            end
            send_cell(v);
        end
        set_config(32'h0, 32'h0, 32'h0);
        for (int p = 0; p < 4; p++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                v[i] = pats[(p + i) % 8];
            end
            send_cell(v);
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 8; ph++)
        begin
            set_config(rand_cfg(), rand_cfg(), rand_cfg());
            quiet = (ph == 3);
            send_random(140);
            quiet = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        set_config($urandom_range(0, 32'h0400_0000), $urandom, $urandom);
        hold_request = 300;
        send_random(200);
        // pause until everything is back, then continue
        go_idle();
        send_random(60);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        go_idle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/dc_pkg.sv
hdl/dc_isqrt.sv
hdl/dc_div.sv
hdl/dispersion_coefficients.sv
bench/dispersion_coefficients_tb.sv
